>>> src/cwrs_pkg.sv
// Shared types and constants for the cumulative-weight roulette selector.
// No dependencies; used by cwrs_search, the top level and the testbench.
package cwrs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_BITS    = 8;
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int WEIGHT_BITS = 32;

    // Random point and scaling
    localparam int FRAC_BITS   = 16;
    localparam int TOTAL_BITS  = 32;
    localparam int PROD_BITS   = FRAC_BITS + TOTAL_BITS;

    // Input item kinds (carried on tuser)
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // Table write request
    typedef struct packed {
        logic                   en;
        logic [IDX_BITS-1:0]    index;
        logic [WEIGHT_BITS-1:0] weight;
    } cwrs_write_t;

    // Scan result, valid for one cycle when done is high
    typedef struct packed {
        logic                done;
        logic                not_found;
        logic [IDX_BITS-1:0] index;
    } cwrs_result_t;

endpackage

>>> src/cwrs_search.sv
// Weight table memory and the linear scan that finds the first entry above a threshold.
// Depends on cwrs_pkg.
module cwrs_search
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cwrs_pkg::cwrs_write_t            wr,
    input  logic                             start,
    input  logic [cwrs_pkg::WEIGHT_BITS-1:0] threshold,
    input  logic [cwrs_pkg::CNT_BITS-1:0]    entries,
    output cwrs_pkg::cwrs_result_t           result
);

    logic [cwrs_pkg::WEIGHT_BITS-1:0] mem [cwrs_pkg::TABLE_DEPTH];
    logic [cwrs_pkg::WEIGHT_BITS-1:0] rd_data_reg;

    logic                             active_reg;
    logic                             cmp_pend_reg;
    logic                             cmp_valid_reg;
    logic [cwrs_pkg::CNT_BITS-1:0]    idx_reg;
    logic [cwrs_pkg::IDX_BITS-1:0]    cmp_idx_reg;
    cwrs_pkg::cwrs_result_t           result_reg;

    logic [cwrs_pkg::CNT_BITS-1:0]    limit;
    logic                             hit;
    logic                             finish;

    // Saturate the entry count to the table depth
    assign limit = (entries > cwrs_pkg::CNT_BITS'(cwrs_pkg::TABLE_DEPTH))
                   ? cwrs_pkg::CNT_BITS'(cwrs_pkg::TABLE_DEPTH) : entries;

    // The one comparator, shared by every entry of the scan
    assign hit = rd_data_reg > threshold;

    // Stop at the first hit or at the first index past the count
    assign finish = !start && active_reg && cmp_pend_reg && (!cmp_valid_reg || hit);

    // Table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.index] <= wr.weight;
        end
        rd_data_reg <= mem[idx_reg[cwrs_pkg::IDX_BITS-1:0]];
    end

    // Hold the index that matches the word in rd_data_reg
    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            cmp_idx_reg <= idx_reg[cwrs_pkg::IDX_BITS-1:0];
        end
    end

    // Scan sequencer: issue one read a cycle, compare each word in the cycle after its read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            result_reg    <= '0;
        end
        else
        begin
            result_reg.done <= finish;
            if (start)
            begin
                active_reg   <= 1'b1;
                cmp_pend_reg <= 1'b0;
                idx_reg      <= '0;
            end
            else if (active_reg)
            begin
                idx_reg       <= idx_reg + 1'b1;
                cmp_pend_reg  <= !finish;
                cmp_valid_reg <= idx_reg < limit;
                if (finish)
                begin
                    active_reg           <= 1'b0;
                    result_reg.not_found <= !cmp_valid_reg;
                    result_reg.index     <= cmp_valid_reg ? cmp_idx_reg : '0;
                end
            end
        end
    end

    assign result = result_reg;

endmodule

>>> src/cumulative_weight_roulette_select_top.sv
// Top level of the cumulative-weight roulette selector: stream handshake,
// threshold scaling and output register. Depends on cwrs_pkg and cwrs_search.
//
// A write beat (tuser = 0) stores one cumulative weight and leaves s_tready high.
// A select beat (tuser = 1) holds s_tready low through its steps: the 16 x 32
// multiply that scales the random point, the start of the scan, the registered
// table read, then one compare per entry read through the memory's single read
// port, ending at the first entry above the threshold or at the end check just
// past the last entry in use, with the entry count saturated to 256, and last
// the hand-off of the result to the output register. No new beat is taken
// before that hand-off. A result
// waiting in the output register on m_tready does not block new beats; the
// next select's result, once finished, holds s_tready low until it is free.
module cumulative_weight_roulette_select_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // entry_index[7:0], entry_weight[39:8],
                                   // random_fraction[55:40], total_weight[87:56]
    input  logic [0:0]  s_tuser,   // command[0]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // selected_index[7:0]
    output logic [0:0]  m_tuser,   // not_found[0]
    // Configuration: entries_in_use
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]                        state_reg;
    logic [cwrs_pkg::CNT_BITS-1:0]     entries_reg;
    logic [cwrs_pkg::FRAC_BITS-1:0]    frac_reg;
    logic [cwrs_pkg::TOTAL_BITS-1:0]   total_reg;
    logic [cwrs_pkg::WEIGHT_BITS-1:0]  thr_reg;
    logic                              start_reg;
    logic                              res_nf_reg;
    logic [cwrs_pkg::IDX_BITS-1:0]     res_idx_reg;
    logic                              m_tvalid_reg;
    logic [cwrs_pkg::IDX_BITS-1:0]     m_tdata_reg;
    logic                              m_tuser_reg;

    logic                              in_beat;
    logic                              out_free;
    logic [cwrs_pkg::PROD_BITS-1:0]    product;
    cwrs_pkg::cwrs_write_t             wr;
    cwrs_pkg::cwrs_result_t            result;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Table writes go straight to the memory
    assign wr.en     = in_beat && (s_tuser[0] == cwrs_pkg::CMD_WRITE);
    assign wr.index  = s_tdata[7:0];
    assign wr.weight = s_tdata[39:8];

    // Scale the random point: frac * total, keep bits above the fraction
    assign product = cwrs_pkg::PROD_BITS'(frac_reg) * cwrs_pkg::PROD_BITS'(total_reg);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= cwrs_pkg::CNT_BITS'(cwrs_pkg::TABLE_DEPTH);
        end
        else if (cfg_we)
        begin
            entries_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            frac_reg  <= s_tdata[55:40];
            total_reg <= s_tdata[87:56];
        end
        if (state_reg == ST_MUL)
        begin
            thr_reg <= product[cwrs_pkg::PROD_BITS-1:cwrs_pkg::FRAC_BITS];
        end
        if (result.done)
        begin
            res_nf_reg  <= result.not_found;
            res_idx_reg <= result.index;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat && (s_tuser[0] == cwrs_pkg::CMD_SELECT))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    start_reg <= 1'b1;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (result.done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: load from the held result, drop on m_tready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else if ((state_reg == ST_HOLD) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= res_idx_reg;
            m_tuser_reg  <= res_nf_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    cwrs_search u_search
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .start     (start_reg),
        .threshold (thr_reg),
        .entries   (entries_reg),
        .result    (result)
    );

endmodule

>>> src/cwrs_checker.sv
// Port-level checks for the roulette selector top level, attached by bind.
// Depends only on the top level's ports.
module cwrs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled output beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // A select beat makes the block busy in the next cycle
    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("ready after a select beat");

    // A write beat leaves the block ready for the next beat
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("not ready after a write beat");

    // A not-found result carries index zero
    a_nf_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("not-found result with nonzero index");

endmodule

bind cumulative_weight_roulette_select_top cwrs_checker u_cwrs_checker (.*);

>>> dv/cumulative_weight_roulette_select_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cumulative_weight_roulette_select_top.
// Depends on cwrs_pkg and the selector RTL; builds its own prediction of every select.
module cumulative_weight_roulette_select_top_tb;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 9;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          LONG_HOLD    = 800;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam logic [cwrs_pkg::CNT_BITS-1:0] SPAN_RESET =
        cwrs_pkg::CNT_BITS'(cwrs_pkg::TABLE_DEPTH);

    // One input beat, unpacked into its fields
    typedef struct {
        logic                             cmd;
        logic [cwrs_pkg::IDX_BITS-1:0]    index;
        logic [cwrs_pkg::WEIGHT_BITS-1:0] weight;
        logic [cwrs_pkg::FRAC_BITS-1:0]   frac;
        logic [cwrs_pkg::TOTAL_BITS-1:0]  total;
    } wheel_beat_t;

    // One predicted selection
    typedef struct packed {
        logic                          not_found;
        logic [cwrs_pkg::IDX_BITS-1:0] index;
    } pick_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [8:0]  cfg_wdata = '0;

    // Predictor state: mirror of the weight table and of the entry count
    logic [cwrs_pkg::WEIGHT_BITS-1:0] wheel_weights [cwrs_pkg::TABLE_DEPTH] =
        '{default: '0};
    logic [cwrs_pkg::CNT_BITS-1:0]    wheel_span;

    // Stimulus side bookkeeping
    wheel_beat_t                     pending_beats [$];
    pick_t                           expected_picks [$];
    wheel_beat_t                     live_beat;
    pick_t                           oldest_pick;
    bit                              gen_written [cwrs_pkg::TABLE_DEPTH] = '{default: 1'b0};
    int unsigned                     gen_span  = cwrs_pkg::TABLE_DEPTH;
    logic [cwrs_pkg::TOTAL_BITS-1:0] gen_total = '0;

    bit          sender_gaps     = 1'b1;
    bit          receiver_stalls = 1'b1;
    bit          hold_armed      = 1'b0;
    bit          hold_used;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned cycle_count     = 0;
    int unsigned beats_taken     = 0;
    int unsigned picks_checked   = 0;
    int unsigned picks_missed    = 0;
    int unsigned spans_used      = 0;
    int unsigned failures        = 0;

    cumulative_weight_roulette_select_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // entry_index[7:0], entry_weight[39:8],
                                // random_fraction[55:40], total_weight[87:56]
        .s_tuser   (s_tuser),   // command[0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // selected_index[7:0]
        .m_tuser   (m_tuser),   // not_found[0]
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Scale the random point and find the first entry in use above it
    function automatic pick_t predict_pick(logic [cwrs_pkg::FRAC_BITS-1:0] frac,
                                           logic [cwrs_pkg::TOTAL_BITS-1:0] total);
        logic [cwrs_pkg::PROD_BITS-1:0]  point;
        logic [cwrs_pkg::TOTAL_BITS-1:0] threshold;
        int unsigned                     scanned;
        pick_t                           pick;
        point     = {{cwrs_pkg::TOTAL_BITS{1'b0}}, frac} * {{cwrs_pkg::FRAC_BITS{1'b0}}, total};
        threshold = point[cwrs_pkg::PROD_BITS-1:cwrs_pkg::FRAC_BITS];
        // an entry count past the table depth saturates
        scanned   = (wheel_span > cwrs_pkg::TABLE_DEPTH) ? cwrs_pkg::TABLE_DEPTH : wheel_span;
        pick.not_found = 1'b1;
        pick.index     = '0;
        for (int i = 0; i < scanned && pick.not_found; i++)
        begin
            if (wheel_weights[i] > threshold)
            begin
                pick.index     = cwrs_pkg::IDX_BITS'(i);
                pick.not_found = 1'b0;
            end
        end
        return pick;
    endfunction

    // Drive input beats; update the predictor as each beat is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                beats_taken++;
                if (live_beat.cmd == cwrs_pkg::CMD_WRITE)
                begin
                    if (int'(live_beat.index) < cwrs_pkg::TABLE_DEPTH)
                        wheel_weights[live_beat.index] = live_beat.weight;
                end
                else
                begin
                    expected_picks.insert(expected_picks.size(),
                                          predict_pick(live_beat.frac, live_beat.total));
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    live_beat = pending_beats.pop_front();
                    s_tdata  <= {live_beat.total, live_beat.frac,
                                 live_beat.weight, live_beat.index};
                    s_tuser  <= live_beat.cmd;
                    s_tvalid <= 1'b1;
                    gap_left <= sender_gaps ? pick_gap() : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Track the entry count exactly as the block latches it
    always @(posedge clk)
    begin
        if (!rst_n)
            wheel_span <= SPAN_RESET;
        else if (cfg_we)
            wheel_span <= cfg_wdata;
    end

    // Check result beats and drive the receiver's ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_used  <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_picks.size() == 0)
                begin
                    $error("result beat with no select pending: selected_index %0d not_found %0d",
                           m_tdata, m_tuser[0]);
                    failures++;
                end
                else
                begin
                    oldest_pick = expected_picks.pop_front();
                    if (m_tdata !== oldest_pick.index)
                    begin
                        $error("selected_index mismatch: expected %0d, actual %0d",
                               oldest_pick.index, m_tdata);
                        failures++;
                    end
                    if (m_tuser[0] !== oldest_pick.not_found)
                    begin
                        $error("not_found mismatch: expected %0d, actual %0d",
                               oldest_pick.not_found, m_tuser[0]);
                        failures++;
                    end
                    picks_checked++;
                    if (oldest_pick.not_found)
                        picks_missed++;
                end
            end
            // long hold first, then random stalls
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (hold_armed && !hold_used)
            begin
                hold_left <= LONG_HOLD;
                hold_used <= 1'b1;
                m_tready  <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 99) < 25)
            begin
                stall_left <= pick_gap();
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_picks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_write(int unsigned idx, logic [cwrs_pkg::WEIGHT_BITS-1:0] weight);
        wheel_beat_t beat;
        beat.cmd    = cwrs_pkg::CMD_WRITE;
        beat.index  = cwrs_pkg::IDX_BITS'(idx);
        beat.weight = weight;
        beat.frac   = cwrs_pkg::FRAC_BITS'($urandom_range(0, 65535));
        beat.total  = $urandom();
        pending_beats.insert(pending_beats.size(), beat);
        gen_written[idx] = 1'b1;
    endtask

    task automatic push_select(logic [cwrs_pkg::FRAC_BITS-1:0] frac,
                               logic [cwrs_pkg::TOTAL_BITS-1:0] total);
        wheel_beat_t beat;
        beat.cmd    = cwrs_pkg::CMD_SELECT;
        beat.index  = cwrs_pkg::IDX_BITS'($urandom_range(0, 255));
        beat.weight = $urandom();
        beat.frac   = frac;
        beat.total  = total;
        pending_beats.insert(pending_beats.size(), beat);
    endtask

    // Select with a point drawn mostly against the loaded total
    task automatic random_select();
        logic [cwrs_pkg::FRAC_BITS-1:0]  frac;
        logic [cwrs_pkg::TOTAL_BITS-1:0] total;
        int unsigned                     r;
        r = $urandom_range(0, 99);
        if (r < 10)
            frac = '0;
        else if (r < 20)
            frac = '1;
        else
            frac = cwrs_pkg::FRAC_BITS'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 60)
            total = gen_total;
        else if (r < 70)
            total = gen_total + $urandom_range(1, 1 << 20);
        else if (r < 80)
            total = $urandom();
        else if (r < 88)
            total = 32'd65536;
        else if (r < 94)
            total = '0;
        else
            total = '1;
        push_select(frac, total);
    endtask

    // Lowest entry in use that was never written, or -1 when all are loaded
    function automatic int first_hole();
        int unsigned n;
        n = (gen_span > cwrs_pkg::TABLE_DEPTH) ? cwrs_pkg::TABLE_DEPTH : gen_span;
        for (int i = 0; i < n; i++)
        begin
            if (!gen_written[i])
                return i;
        end
        return -1;
    endfunction

    // Load entries 0..n-1 with a non-decreasing random sequence
    task automatic fill_cumulative(int unsigned n, int unsigned step_max);
        longint unsigned acc;
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) != 0)
                acc += $urandom_range(0, step_max);
            if (acc > 64'hFFFF_FFFF)
                acc = 64'hFFFF_FFFF;
            push_write(i, acc[cwrs_pkg::WEIGHT_BITS-1:0]);
        end
        gen_total = acc[cwrs_pkg::TOTAL_BITS-1:0];
    endtask

    // Mix of selects and table rewrites; holes in use are filled first
    task automatic run_mix(int unsigned n, int unsigned select_pct);
        int                               hole;
        logic [cwrs_pkg::WEIGHT_BITS-1:0] weight;
        for (int k = 0; k < n; k++)
        begin
            hole = first_hole();
            if (hole >= 0)
            begin
                push_write(hole, $urandom());
            end
            else if ($urandom_range(0, 99) < select_pct)
            begin
                random_select();
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       weight = '0;
                    1:       weight = '1;
                    default: weight = $urandom();
                endcase
                push_write($urandom_range(0, cwrs_pkg::TABLE_DEPTH - 1), weight);
            end
        end
    endtask

    // Wait until the block is idle with nothing outstanding
    task automatic settle();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || s_tvalid || expected_picks.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_span(int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cwrs_pkg::CNT_BITS'(value);
        gen_span   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        spans_used++;
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: four-entry table with equal weights and extreme points
        set_span(4);
        push_write(0, 32'd0);
        push_write(1, 32'd100);
        push_write(2, 32'd100);
        push_write(3, 32'hFFFF_FFFF);
        push_write(255, 32'hFFFF_FFFF);
        push_select(16'h0000, 32'h0000_0000);
        push_select(16'hFFFF, 32'hFFFF_FFFF);
        push_select(16'hFFFF, 32'd65536);
        push_select(16'h8000, 32'd200);
        push_select(16'h8000, 32'd198);
        push_select(16'h0001, 32'hFFFF_FFFF);
        push_select(16'hFFFF, 32'h0000_0000);
        // nothing above the point
        push_write(3, 32'd50);
        push_select(16'h8000, 32'd200);
        settle();
        set_span(1);
        push_select(16'h0000, 32'h0000_0000);
        push_write(0, 32'd1);
        push_select(16'h0000, 32'h0000_0000);
        settle();
        // empty scan
        set_span(0);
        push_select(16'h1234, 32'h0001_0000);
        settle();

        // Full table, then a long receiver hold while selects keep coming
        set_span(cwrs_pkg::TABLE_DEPTH);
        fill_cumulative(cwrs_pkg::TABLE_DEPTH, 32'h00FF_FFFF);
        settle();
        sender_gaps = 1'b0;
        hold_armed  = 1'b1;
        for (int k = 0; k < 120; k++)
            random_select();
        settle();
        sender_gaps = 1'b1;

        // Entry count past the table depth saturates
        set_span(511);
        run_mix(80, 70);
        settle();

        // Small spans, one of them without any idling
        set_span(1);
        fill_cumulative(1, 1000);
        run_mix(30, 75);
        settle();
        set_span($urandom_range(2, 16));
        fill_cumulative(gen_span, 32'h0000_FFFF);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        run_mix(30, 75);
        settle();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        set_span($urandom_range(17, 40));
        fill_cumulative(gen_span, 32'h000F_FFFF);
        run_mix(30, 75);
        settle();

        // Oversized count again over a rewritten table
        set_span($urandom_range(cwrs_pkg::TABLE_DEPTH + 1, 510));
        run_mix(60, 80);
        settle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_picks.size() != 0)
        begin
            $error("%0d selections never answered", expected_picks.size());
            failures++;
        end
        $display("Took %0d beats over %0d entry-count settings; checked %0d selections",
                 beats_taken, spans_used, picks_checked);
        $display("(%0d with no entry above the point), %0d cycles",
                 picks_missed, cycle_count);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
src/cwrs_pkg.sv
src/cwrs_search.sv
src/cumulative_weight_roulette_select_top.sv
src/cwrs_checker.sv
dv/cumulative_weight_roulette_select_top_tb.sv
